/* src/fbpt_pkg.sv */
// fbpt_pkg: shared constants and controller/datapath interface types for the
// base-2 fermat probable-prime tester. no dependencies.
`default_nettype none

package fbpt_pkg;

    // default operand width, candidate field width and packed result width
    localparam int NUM_WIDTH_DEF = 64;
    localparam int CAND_WIDTH    = 64;
    localparam int OUT_TDATA_W   = 8;

    // commands from controller to datapath
    typedef struct packed {
        logic load;        // capture candidate, set up exponent, acc and base
        logic mul_start;   // clear partial remainder, load multiplier operands
        logic mul_sel_sq;  // 1: base * base, 0: acc * base
        logic dbl;         // r = 2r mod m
        logic add;         // r = r + a mod m
        logic wb_acc;      // acc takes the finished product
        logic wb_base;     // base takes the finished product, exponent shifts
        logic out_load;    // capture result flags into the output register
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic zero_mod;    // modulus is zero
        logic e_zero;      // exponent exhausted
        logic e_lsb;       // current exponent bit
        logic e_one;       // exponent is exactly one
        logic b_msb;       // current multiplier bit
        logic cnt_last;    // last multiplier bit in progress
    } stat_t;

endpackage

`default_nettype wire

/* src/fbpt_datapath.sv */
// fbpt_datapath: operand registers, exponent shifter and the shared
// shift-and-add modular multiplier with one add/reduce unit.
// depends on fbpt_pkg.
`default_nettype none

module fbpt_datapath
    import fbpt_pkg::*;
#(
    parameter int NUM_WIDTH = NUM_WIDTH_DEF
) (
    input  wire logic                  aclk,
    input  wire logic [CAND_WIDTH-1:0] candidate,
    input  wire cmd_t                  cmd,
    output stat_t                      stat,
    output logic                       probable_prime,
    output logic                       zero_modulus
);

    localparam int CNT_W = (NUM_WIDTH > 1) ? $clog2(NUM_WIDTH) : 1;
    localparam logic [NUM_WIDTH-1:0] ONE = NUM_WIDTH'(1);
    localparam logic [NUM_WIDTH-1:0] TWO = NUM_WIDTH'(2);
    localparam logic [CNT_W-1:0]     CNT_LAST = CNT_W'(NUM_WIDTH - 1);

    logic [NUM_WIDTH-1:0] m_reg, e_reg, acc_reg, base_reg, r_reg, a_reg, b_reg;
    logic [NUM_WIDTH-1:0] m_next, e_next, acc_next, base_next, r_next, a_next, b_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 zero_reg, zero_next;
    logic                 prime_reg, prime_next;
    logic                 zflag_reg, zflag_next;

    // shared modular adder: x, y < m
    logic [NUM_WIDTH-1:0] add_y;
    logic [NUM_WIDTH:0]   add_sum;
    logic [NUM_WIDTH+1:0] add_diff;
    logic [NUM_WIDTH-1:0] add_res;

    logic [NUM_WIDTH-1:0] cand_m;

    assign cand_m   = candidate[NUM_WIDTH-1:0];
    assign add_y    = cmd.add ? a_reg : r_reg;
    assign add_sum  = {1'b0, r_reg} + {1'b0, add_y};
    assign add_diff = {1'b0, add_sum} - {2'b00, m_reg};
    // no borrow means sum >= m
    assign add_res  = add_diff[NUM_WIDTH+1] ? add_sum[NUM_WIDTH-1:0]
                                            : add_diff[NUM_WIDTH-1:0];

    always_comb begin
        m_next     = m_reg;
        e_next     = e_reg;
        acc_next   = acc_reg;
        base_next  = base_reg;
        r_next     = r_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        cnt_next   = cnt_reg;
        zero_next  = zero_reg;
        prime_next = prime_reg;
        zflag_next = zflag_reg;

        if (cmd.load) begin
            m_next    = cand_m;
            e_next    = cand_m - ONE;
            acc_next  = ONE;
            // 2 mod 2 is zero, every larger modulus leaves 2 as is
            base_next = (cand_m == TWO) ? '0 : TWO;
            zero_next = (cand_m == '0);
        end

        if (cmd.dbl) begin
            r_next = add_res;
            if (!b_reg[NUM_WIDTH-1]) begin
                b_next   = {b_reg[NUM_WIDTH-2:0], 1'b0};
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end

        if (cmd.add) begin
            r_next   = add_res;
            b_next   = {b_reg[NUM_WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg + CNT_W'(1);
        end

        if (cmd.wb_acc) begin
            acc_next = r_reg;
        end

        if (cmd.wb_base) begin
            base_next = r_reg;
            e_next    = {1'b0, e_reg[NUM_WIDTH-1:1]};
        end

        if (cmd.mul_start) begin
            r_next   = '0;
            cnt_next = '0;
            a_next   = cmd.mul_sel_sq ? base_reg : acc_reg;
            b_next   = base_reg;
        end

        if (cmd.out_load) begin
            prime_next = !zero_reg && (acc_reg == ONE);
            zflag_next = zero_reg;
        end
    end

    always_ff @(posedge aclk) begin
        m_reg     <= m_next;
        e_reg     <= e_next;
        acc_reg   <= acc_next;
        base_reg  <= base_next;
        r_reg     <= r_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        cnt_reg   <= cnt_next;
        zero_reg  <= zero_next;
        prime_reg <= prime_next;
        zflag_reg <= zflag_next;
    end

    assign stat.zero_mod = zero_reg;
    assign stat.e_zero   = (e_reg == '0);
    assign stat.e_lsb    = e_reg[0];
    assign stat.e_one    = (e_reg == ONE);
    assign stat.b_msb    = b_reg[NUM_WIDTH-1];
    assign stat.cnt_last = (cnt_reg == CNT_LAST);

    assign probable_prime = prime_reg;
    assign zero_modulus   = zflag_reg;

endmodule

`default_nettype wire

/* src/fbpt_ctrl.sv */
// fbpt_ctrl: sequencer for the square-and-multiply loop and the result
// handshake. depends on fbpt_pkg.
`default_nettype none

module fbpt_ctrl
    import fbpt_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  wire logic  m_ready,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_CHECK = 6'b000010,
        ST_DBL   = 6'b000100,
        ST_ADD   = 6'b001000,
        ST_WB    = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   tgt_sq_reg, tgt_sq_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        tgt_sq_next  = tgt_sq_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        s_ready      = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (stat.zero_mod || stat.e_zero) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.mul_start  = 1'b1;
                    cmd.mul_sel_sq = !stat.e_lsb;
                    tgt_sq_next    = !stat.e_lsb;
                    state_next     = ST_DBL;
                end
            end
            ST_DBL: begin
                cmd.dbl = 1'b1;
                if (stat.b_msb) begin
                    state_next = ST_ADD;
                end else if (stat.cnt_last) begin
                    state_next = ST_WB;
                end
            end
            ST_ADD: begin
                cmd.add    = 1'b1;
                state_next = stat.cnt_last ? ST_WB : ST_DBL;
            end
            ST_WB: begin
                if (tgt_sq_reg) begin
                    cmd.wb_base = 1'b1;
                    state_next  = ST_CHECK;
                end else begin
                    cmd.wb_acc = 1'b1;
                    // last exponent bit: the final square is not needed
                    if (stat.e_one) begin
                        state_next = ST_DONE;
                    end else begin
                        cmd.mul_start  = 1'b1;
                        cmd.mul_sel_sq = 1'b1;
                        tgt_sq_next    = 1'b1;
                        state_next     = ST_DBL;
                    end
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            tgt_sq_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            tgt_sq_reg  <= tgt_sq_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

/* src/fermat_base2_prime_test.sv */
// fermat_base2_prime_test: top level, joins controller and datapath.
// depends on fbpt_pkg, fbpt_ctrl, fbpt_datapath.
//
//   channel | dir | handshake                     | payload
//   --------+-----+-------------------------------+------------------------------------
//   s_axis  | in  | s_axis_tvalid / s_axis_tready | tdata[63:0] candidate
//   m_axis  | out | m_axis_tvalid / m_axis_tready | tdata[0] probable_prime,
//           |     |                               | tdata[1] zero_modulus, rest zero
//
// one candidate in flight at a time; a transfer is accepted only while idle.
// each modular product runs in the shared shift-and-add unit as one double per
// multiplier bit, plus one add per set multiplier bit.
// a candidate needs up to two products per exponent bit, with check and
// write-back states between products; zero and one need no product at all.
// the finished result waits in an output register, so the next candidate is
// taken while m_axis is stalled.
// reset (aresetn, synchronous) clears the sequencer and the output valid.
`default_nettype none

module fermat_base2_prime_test
    import fbpt_pkg::*;
#(
    parameter int NUM_WIDTH = NUM_WIDTH_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [CAND_WIDTH-1:0]  s_axis_tdata,   // [63:0] candidate
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata    // [0] probable_prime, [1] zero_modulus
);

    cmd_t  cmd;
    stat_t stat;
    logic  probable_prime;
    logic  zero_modulus;

    fbpt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    fbpt_datapath #(
        .NUM_WIDTH (NUM_WIDTH)
    ) u_datapath (
        .aclk           (aclk),
        .candidate      (s_axis_tdata),
        .cmd            (cmd),
        .stat           (stat),
        .probable_prime (probable_prime),
        .zero_modulus   (zero_modulus)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W-2){1'b0}}, zero_modulus, probable_prime};

endmodule

`default_nettype wire

/* tb/sv/fermat_base2_prime_test_test.sv */
// fermat_base2_prime_test_test: self-checking bench for the base-2 fermat tester.
// depends on fbpt_pkg and fermat_base2_prime_test; a 128-bit modpow predicts each result.
`timescale 1ns / 100ps

module fermat_base2_prime_test_test;
    import fbpt_pkg::*;

    localparam int CYCLE_LIMIT  = 5_000_000;
    localparam int RANDOM_ITEMS = 100;
    localparam int DRAIN_CYCLES = 64;

    // packed in result order: bit 0 probable_prime, bit 1 zero_modulus
    typedef struct packed {
        logic zero_modulus;
        logic probable_prime;
    } fermat_flags_t;

    class primality_scoreboard;
        fermat_flags_t expected_flags[$];
        int            errors;

        function new();
            errors = 0;
        endfunction

        // 2^(n-1) mod n with exact double-width products
        function fermat_flags_t predict(input logic [CAND_WIDTH-1:0] cand);
            logic [CAND_WIDTH-1:0]   expo;
            logic [2*CAND_WIDTH-1:0] modulus;
            logic [2*CAND_WIDTH-1:0] acc;
            logic [2*CAND_WIDTH-1:0] base;
            fermat_flags_t           flags;
            flags = '0;
            if (cand == '0) begin
                flags.zero_modulus = 1'b1;
                return flags;
            end
            modulus = {{CAND_WIDTH{1'b0}}, cand};
            expo    = cand - 1'b1;
            acc     = (2*CAND_WIDTH)'(1);
            base    = (2*CAND_WIDTH)'(2);
            while (expo != '0) begin
                if (expo[0]) begin
                    acc = (acc * base) % modulus;
                end
                base = (base * base) % modulus;
                expo = expo >> 1;
            end
            flags.probable_prime = (acc == 1);
            return flags;
        endfunction

        function void note_candidate(input logic [CAND_WIDTH-1:0] cand);
            expected_flags.push_back(predict(cand));
        endfunction

        function void check_result(input logic [OUT_TDATA_W-1:0] tdata);
            fermat_flags_t want;
            if (expected_flags.size() == 0) begin
                $error("result transfer with no candidate pending: tdata %h", tdata);
                errors++;
                return;
            end
            want = expected_flags.pop_front();
            if (tdata[0] !== want.probable_prime) begin
                $error("probable_prime: expected %0d, got %0d", want.probable_prime, tdata[0]);
                errors++;
            end
            if (tdata[1] !== want.zero_modulus) begin
                $error("zero_modulus: expected %0d, got %0d", want.zero_modulus, tdata[1]);
                errors++;
            end
            if (tdata[OUT_TDATA_W-1:2] !== '0) begin
                $error("padding: expected 0, got %h", tdata[OUT_TDATA_W-1:2]);
                errors++;
            end
        endfunction
    endclass

    logic                   aclk          = 1'b0;
    logic                   aresetn       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [CAND_WIDTH-1:0]  s_axis_tdata  = '0;    // [63:0] candidate
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;          // [0] probable_prime, [1] zero_modulus

    primality_scoreboard sb = new();

    int cycle_count = 0;
    int sink_hold   = 0;
    int sink_calm   = 0;

    fermat_base2_prime_test i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
            return $urandom_range(0, 2);
        end else if (roll < 95) begin
            return $urandom_range(3, 10);
        end else begin
            return $urandom_range(20, 200);
        end
    endfunction

    // random candidate, mostly narrow so the run stays short
    function automatic logic [CAND_WIDTH-1:0] pick_candidate();
        logic [CAND_WIDTH-1:0] value;
        int                    roll;
        int                    width;
        roll  = $urandom_range(0, 99);
        value = {$urandom, $urandom};
        if (roll < 4) begin
            return '0;
        end else if (roll < 8) begin
            return CAND_WIDTH'(1);
        end else if (roll < 23) begin
            width = $urandom_range(33, 64);
        end else if (roll < 33) begin
            width = $urandom_range(21, 32);
        end else begin
            width = $urandom_range(2, 20);
        end
        if (width < CAND_WIDTH) begin
            value = value & ((64'd1 << width) - 1);
        end
        value[width-1] = 1'b1;
        // odd candidates give primes often enough to see both answers
        if ($urandom_range(0, 9) < 7) begin
            value[0] = 1'b1;
        end
        return value;
    endfunction

    task automatic send_candidate(input logic [CAND_WIDTH-1:0] value, input int gap);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= {$urandom, $urandom};
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        do begin
            @(posedge aclk);
        end while (!s_axis_tready);
    endtask

    // transfer monitors: values read at the edge are the pre-edge values
    always @(posedge aclk) begin
        if (aresetn && s_axis_tvalid && s_axis_tready) begin
            sb.note_candidate(s_axis_tdata);
        end
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tdata);
        end
    end

    // result sink: random stalls, with calm stretches of steady ready
    always @(posedge aclk) begin
        if (sink_calm > 0) begin
            sink_calm     <= sink_calm - 1;
            m_axis_tready <= 1'b1;
        end else if (sink_hold > 0) begin
            sink_hold     <= sink_hold - 1;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 199) == 0) begin
            sink_calm     <= $urandom_range(500, 5000);
            m_axis_tready <= 1'b1;
        end else if ($urandom_range(0, 3) == 0) begin
            sink_hold     <= pick_gap();
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("fermat_base2_prime_test_test: FAIL");
            $finish;
        end
    end

    initial begin
        logic [CAND_WIDTH-1:0] directed_list[$];
        int                    gap;

        directed_list = '{
            64'd0, 64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd5, 64'd9,
            64'd341,                      // base-2 pseudoprime
            64'd561,                      // carmichael number
            64'd65537,
            64'h0000_0000_FFFF_FFFB,      // largest 32-bit prime
            64'h1FFF_FFFF_FFFF_FFFF,      // mersenne prime 2^61-1
            64'hFFFF_FFFF_FFFF_FFC5,      // largest 64-bit prime
            64'h8000_0000_0000_0000,
            64'hFFFF_FFFF_FFFF_FFFF,
            64'd1
        };

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // back-to-back transfers in the directed part except a few gaps
        foreach (directed_list[idx]) begin
            gap = (idx % 4 == 3) ? pick_gap() : 0;
            send_candidate(directed_list[idx], gap);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            gap = ((n / 20) % 2 == 1) ? 0 : pick_gap();
            send_candidate(pick_candidate(), gap);
        end
        s_axis_tvalid <= 1'b0;
        // let the monitor log the last transfer before polling the queue
        @(posedge aclk);

        while (sb.expected_flags.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.errors == 0) begin
            $display("fermat_base2_prime_test_test: PASS");
        end else begin
            $display("fermat_base2_prime_test_test: FAIL");
        end
        $finish;
    end

endmodule

/* sim.f */
src/fbpt_pkg.sv
src/fbpt_datapath.sv
src/fbpt_ctrl.sv
src/fermat_base2_prime_test.sv
tb/sv/fermat_base2_prime_test_test.sv
